// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL.
// Defining NO_ASSERTIONS makes every use expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising clock edge, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== src/thc_pkg.sv =====
package thc_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 256;
    localparam int PROBE_WINDOW  = 8;
    localparam int PAYLOAD_BITS  = 32;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int PCNT_W = (PROBE_WINDOW > 1) ? $clog2(PROBE_WINDOW) : 1;

    // Address bytes hashed per family.
    localparam int V4_BYTES = 4;
    localparam int V6_BYTES = 16;
    localparam int BYTE_W   = $clog2(V6_BYTES);

    // FNV-1a constants.
    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;

    localparam logic [31:0] TTL_RESET = 32'd86400;

    // Request modes.
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_STORE  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic        is_ipv6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [31:0] now_seconds;
        logic [31:0] store_value;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] found_value;
    } t_rsp;

    typedef struct packed {
        logic                    is_v6;
        logic [63:0]             addr_high;
        logic [63:0]             addr_low;
        logic [31:0]             expiry;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_slot;

endpackage

// ===== src/ttl_hash_cache_linear_probe.sv =====
// Channel     Direction  Signals                         Handshake
// request     in         i_req (t_req)                   start high and busy low
// result      out        o_rsp (t_rsp)                   o_strobe, one cycle, no stall
// config      in         i_cfg_wdata (ttl_seconds)       i_cfg_we
//
// A request keeps busy high through the hash of its 4 (IPv4) or 16 (IPv6)
// address bytes, the home-slot read and the probe of up to PROBE_WINDOW slots,
// and a store also through its write. The byte-serial hash multiplier and the
// single slot-memory read port pace it: one byte, then one probed slot per cycle.
// Reset is synchronous and active low; it clears the valid marks at once, so
// no clearing pass is needed. The result cannot be stalled by the receiver.
`include "assert_macros.svh"

module ttl_hash_cache_linear_probe
    import thc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_strobe,
    output t_rsp        o_rsp,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_HOME,
        S_PROBE,
        S_WRITE
    } t_state;

    // Control state.
    t_state              r_state, n_state;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [31:0]         r_ttl;
    logic                r_strobe, n_strobe;
    t_rsp                r_rsp, n_rsp;

    // Working registers for the request in flight.
    t_req                r_req, n_req;
    logic [127:0]        r_shift, n_shift;
    logic [31:0]         r_hash, n_hash;
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic [IDX_W-1:0]    r_slot, n_slot;
    logic [PCNT_W-1:0]   r_probe, n_probe;
    logic [IDX_W-1:0]    r_victim, n_victim;
    logic [31:0]         r_best, n_best;
    logic                r_have, n_have;

    // Slot memory: one write port, one registered read port.
    t_slot               r_mem [TABLE_ENTRIES];
    t_slot               r_rd;
    logic [IDX_W-1:0]    rd_addr;
    logic                mem_we;
    logic                clr_valid;
    t_slot               wr_entry;

    logic [7:0]          cur_byte;
    logic [BYTE_W-1:0]   last_byte;
    logic [IDX_W-1:0]    home;
    logic [IDX_W-1:0]    next_slot;
    logic                last_probe;
    logic                cur_valid;
    logic                cur_match;
    logic                cur_expired;
    logic [32:0]         expiry_sum;

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // The address is hashed from its most significant byte down, so the next
    // byte always sits at the top of the shift register.
    assign cur_byte  = r_shift[127:120];
    assign last_byte = r_req.is_ipv6 ? BYTE_W'(V6_BYTES - 1) : BYTE_W'(V4_BYTES - 1);

    assign home       = r_hash[IDX_W-1:0] & IDX_MASK;
    assign next_slot  = (r_slot + IDX_W'(1)) & IDX_MASK;
    assign last_probe = (r_probe == PCNT_W'(PROBE_WINDOW - 1));

    // Slot checks on the entry that the memory returned this cycle. Fields of a
    // slot whose valid mark is clear are never used.
    assign cur_valid   = r_valid[r_slot];
    assign cur_expired = (r_req.now_seconds >= r_rd.expiry);
    always_comb begin
        if (r_rd.is_v6 != r_req.is_ipv6) begin
            cur_match = 1'b0;
        end else if (r_req.is_ipv6) begin
            cur_match = (r_rd.addr_high == r_req.addr_high) &&
                        (r_rd.addr_low == r_req.addr_low);
        end else begin
            cur_match = (r_rd.addr_high[63:32] == r_req.addr_high[63:32]);
        end
    end

    // Expiry saturates at the largest 32-bit value.
    assign expiry_sum = {1'b0, r_req.now_seconds} + {1'b0, r_ttl};

    always_comb begin
        wr_entry.is_v6     = r_req.is_ipv6;
        wr_entry.addr_high = r_req.addr_high;
        wr_entry.addr_low  = r_req.addr_low;
        wr_entry.expiry    = expiry_sum[32] ? 32'hFFFF_FFFF : expiry_sum[31:0];
        wr_entry.payload   = PAYLOAD_BITS'(r_req.store_value);
    end

    always_comb begin
        n_state   = r_state;
        n_strobe  = 1'b0;
        n_rsp     = r_rsp;
        n_req     = r_req;
        n_shift   = r_shift;
        n_hash    = r_hash;
        n_byte    = r_byte;
        n_slot    = r_slot;
        n_probe   = r_probe;
        n_victim  = r_victim;
        n_best    = r_best;
        n_have    = r_have;
        rd_addr   = next_slot;
        mem_we    = 1'b0;
        clr_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_shift = {i_req.addr_high, i_req.addr_low};
                    n_hash  = FNV_OFFSET;
                    n_byte  = '0;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                // One FNV-1a round per cycle through the single multiplier.
                n_hash  = 32'((r_hash ^ {24'd0, cur_byte}) * FNV_PRIME);
                n_shift = r_shift << 8;
                n_byte  = r_byte + BYTE_W'(1);
                if (r_byte == last_byte) begin
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                rd_addr = home;
                n_slot  = home;
                n_probe = '0;
                n_have  = 1'b0;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                // The next slot is read speculatively; an early exit discards it.
                n_slot  = next_slot;
                n_probe = r_probe + PCNT_W'(1);
                if (r_req.mode == MODE_LOOKUP) begin
                    if (!cur_valid || cur_match || last_probe) begin
                        n_state  = S_IDLE;
                        n_strobe = 1'b1;
                        n_rsp    = '0;
                        if (cur_valid && cur_match) begin
                            if (cur_expired) begin
                                clr_valid = 1'b1;
                            end else begin
                                n_rsp.hit         = 1'b1;
                                n_rsp.found_value = 32'(r_rd.payload);
                            end
                        end
                    end
                end else begin
                    if (!cur_valid || cur_expired || cur_match) begin
                        n_victim = r_slot;
                        n_state  = S_WRITE;
                    end else begin
                        if (!r_have || (r_rd.expiry < r_best)) begin
                            n_victim = r_slot;
                            n_best   = r_rd.expiry;
                            n_have   = 1'b1;
                        end
                        if (last_probe) begin
                            n_state = S_WRITE;
                        end
                    end
                end
            end
            S_WRITE: begin
                mem_we  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_victim] <= wr_entry;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_ttl    <= TTL_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_ttl <= i_cfg_wdata;
            end
            if (clr_valid) begin
                r_valid[r_slot] <= 1'b0;
            end
            if (mem_we) begin
                r_valid[r_victim] <= 1'b1;
            end
        end
        r_rsp    <= n_rsp;
        r_req    <= n_req;
        r_shift  <= n_shift;
        r_hash   <= n_hash;
        r_byte   <= n_byte;
        r_slot   <= n_slot;
        r_probe  <= n_probe;
        r_victim <= n_victim;
        r_best   <= n_best;
        r_have   <= n_have;
    end

    // Only lookups produce a result.
    `ASSERT_CLK(a_strobe_lookup, i_clk, i_rst_n, o_strobe |-> (r_req.mode == MODE_LOOKUP))
    // A miss always reports a zero payload.
    `ASSERT_CLK(a_miss_zero, i_clk, i_rst_n, (o_strobe && !o_rsp.hit) |-> (o_rsp.found_value == 32'd0))
    // An accepted request makes the block busy on the next cycle.
    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    // The probe counter never runs past the window.
    `ASSERT_CLK(a_probe_bound, i_clk, i_rst_n, (r_state == S_PROBE) |-> (r_probe <= PCNT_W'(PROBE_WINDOW - 1)))
    // A store leaves its slot marked valid.
    `ASSERT_CLK(a_store_valid, i_clk, i_rst_n, (r_state == S_WRITE) |=> r_valid[$past(r_victim)])
    // The result strobe is low in the cycle after reset.
    `ASSERT_ALWAYS(a_reset_quiet, i_clk, !$past(i_rst_n) |-> !o_strobe)

endmodule

// ===== bench/ttl_hash_cache_linear_probe_test.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the TTL address cache. Requests are driven on the
// start/busy handshake, and every lookup result that the cache strobes out is
// compared against a shadow copy of the table kept inside the bench. A store
// produces no result, so it only updates the shadow table.
module ttl_hash_cache_linear_probe_test;
    import thc_pkg::*;

    // The longest request is an IPv6 store over a full probe window. Idle waits
    // allow a margin above the time that it keeps busy high.
    localparam int SETTLE_CYCLES  = 32;
    // A request costs at most its random gap plus its busy time, so the whole
    // run stays far below this limit.
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_REQUESTS = 360;
    localparam int POOL_SIZE      = 48;
    localparam int CLUSTER_HOMES  = 6;

    // One shadow slot of the cache.
    typedef struct packed {
        logic                    is_v6;
        logic [63:0]             addr_high;
        logic [63:0]             addr_low;
        logic [31:0]             expiry;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_cache_line;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        o_strobe;
    t_rsp        o_rsp;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    // Shadow of the cache contents and of the lifetime register.
    t_cache_line shadow_line [TABLE_ENTRIES];
    bit          shadow_live [TABLE_ENTRIES];
    logic [31:0] ttl_shadow;

    // Lookup results still owed by the cache, oldest first.
    t_rsp        pending_lookups [$];
    t_rsp        oldest_lookup;

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    // start_held tells whether start was left high after the last accepted
    // request; burst_mode suppresses the random gaps between requests.
    bit          start_held     = 1'b0;
    bit          burst_mode     = 1'b0;

    ttl_hash_cache_linear_probe DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Home slot: 32-bit FNV-1a over the address bytes, byte 0 first, kept to
    // the low index bits. IPv4 hashes only the top four bytes of addr_high.
    function automatic logic [IDX_W-1:0] home_index(input logic v6, input logic [63:0] hi,
                                                  input logic [63:0] lo);
        logic [31:0]  h;
        logic [127:0] addr_bytes;
        int           count;
        int           i;
        h = FNV_OFFSET;
        addr_bytes = {hi, lo};
        count = v6 ? V6_BYTES : V4_BYTES;
        for (i = 0; i < count; i++) begin
            h = (h ^ {24'd0, addr_bytes[127 - 8 * i -: 8]}) * FNV_PRIME;
        end
        return h[IDX_W-1:0];
    endfunction

    // A slot matches when the family agrees and the used address bits agree.
    // IPv4 compares addr_high bits 63:32 only.
    function automatic bit line_matches(input int idx, input t_req req);
        if (shadow_line[idx].is_v6 != req.is_ipv6) begin
            return 1'b0;
        end
        if (req.is_ipv6) begin
            return shadow_line[idx].addr_high == req.addr_high &&
                   shadow_line[idx].addr_low == req.addr_low;
        end
        return shadow_line[idx].addr_high[63:32] == req.addr_high[63:32];
    endfunction

    // Applies one accepted request to the shadow table. A lookup queues the
    // result the cache owes; a store picks its slot and writes it.
    function automatic void predict_cache_access(input t_req req);
        logic [IDX_W-1:0] home;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] victim;
        bit               have_victim;
        logic [32:0]      expiry_sum;
        t_rsp             rsp;
        int               p;
        home = home_index(req.is_ipv6, req.addr_high, req.addr_low);
        if (req.mode == MODE_LOOKUP) begin
            rsp = '0;
            for (p = 0; p < PROBE_WINDOW; p++) begin
                idx = home + p[IDX_W-1:0];
                // An empty slot ends the scan, which is also how a freed
                // entry can hide entries placed further along the window.
                if (!shadow_live[idx]) begin
                    break;
                end
                if (line_matches(idx, req)) begin
                    if (req.now_seconds >= shadow_line[idx].expiry) begin
                        shadow_live[idx] = 1'b0;
                    end else begin
                        rsp.hit = 1'b1;
                        rsp.found_value = 32'(shadow_line[idx].payload);
                    end
                    break;
                end
            end
            pending_lookups.push_back(rsp);
        end else begin
            victim = home;
            have_victim = 1'b0;
            for (p = 0; p < PROBE_WINDOW; p++) begin
                idx = home + p[IDX_W-1:0];
                if (!shadow_live[idx] || req.now_seconds >= shadow_line[idx].expiry ||
                    line_matches(idx, req)) begin
                    victim = idx;
                    break;
                end
                // Strict compare keeps the first slot on an expiry tie.
                if (!have_victim || shadow_line[idx].expiry < shadow_line[victim].expiry) begin
                    victim = idx;
                    have_victim = 1'b1;
                end
            end
            expiry_sum = {1'b0, req.now_seconds} + {1'b0, ttl_shadow};
            shadow_live[victim] = 1'b1;
            shadow_line[victim].is_v6 = req.is_ipv6;
            shadow_line[victim].addr_high = req.addr_high;
            shadow_line[victim].addr_low = req.addr_low;
            shadow_line[victim].expiry = expiry_sum[32] ? 32'hFFFF_FFFF : expiry_sum[31:0];
            shadow_line[victim].payload = req.store_value[PAYLOAD_BITS-1:0];
        end
    endfunction

    // Every strobed result is checked against the oldest lookup still owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_lookups.size() == 0) begin
                $display("%0t: result with no lookup pending: expected none, actual hit=%0b value=%h",
                         $time, o_rsp.hit, o_rsp.found_value);
                mismatch_count++;
            end else begin
                oldest_lookup = pending_lookups.pop_front();
                if (o_rsp.hit !== oldest_lookup.hit) begin
                    $display("%0t: hit mismatch: expected %0b, actual %0b",
                             $time, oldest_lookup.hit, o_rsp.hit);
                    mismatch_count++;
                end
                if (o_rsp.found_value !== oldest_lookup.found_value) begin
                    $display("%0t: found_value mismatch: expected %h, actual %h",
                             $time, oldest_lookup.found_value, o_rsp.found_value);
                    mismatch_count++;
                end
            end
        end
    end

    // A random address of the given family whose hash lands on the given home.
    function automatic t_req address_for_home(input int target, input logic v6);
        t_req req;
        req = '0;
        req.is_ipv6 = v6;
        do begin
            req.addr_high = {$urandom(), $urandom()};
            req.addr_low = {$urandom(), $urandom()};
        end while (home_index(v6, req.addr_high, req.addr_low) != target[IDX_W-1:0]);
        return req;
    endfunction

    function automatic t_req request_of(input t_req addr, input logic op,
                                        input logic [31:0] now, input logic [31:0] value);
        t_req req;
        req = addr;
        req.mode = op;
        req.now_seconds = now;
        req.store_value = value;
        return req;
    endfunction

    // Drops start if the last request left it high. Called before anything
    // that waits, so that no request is accepted by accident.
    task automatic release_start();
        if (start_held) begin
            start <= 1'b0;
            start_held = 1'b0;
        end
    endtask

    // Sends one request. With no gap, start simply stays high from the
    // previous request, so it is never lowered and raised in one step.
    task automatic send_request(input t_req req);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            release_start();
            repeat (gap) @(posedge i_clk);
        end
        i_req <= req;
        if (!start_held) begin
            start <= 1'b1;
        end
        start_held = 1'b1;
        do @(posedge i_clk); while (busy);
        predict_cache_access(req);
    endtask

    // Waits until every owed result has arrived and the cache has gone idle,
    // then lets a store that is still in flight finish as well.
    task automatic wait_until_idle();
        release_start();
        while (pending_lookups.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ttl(input logic [31:0] seconds);
        wait_until_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= seconds;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ttl_shadow = seconds;
    endtask

    // Runs on the lifetime left from reset: a miss on an empty table, a hit
    // that ignores the unused IPv4 bits, a family mismatch in the home slot,
    // and an expired entry that is freed by the lookup that finds it.
    task automatic test_default_ttl_and_match();
        t_req addr_a;
        t_req addr_a_noise;
        t_req addr_b;
        addr_a = address_for_home(16, 1'b0);
        addr_a_noise = addr_a;
        addr_a_noise.addr_high[31:0] = ~addr_a.addr_high[31:0];
        addr_a_noise.addr_low = ~addr_a.addr_low;
        // An IPv6 address with the same top word and the same home slot.
        addr_b = addr_a;
        addr_b.is_ipv6 = 1'b1;
        do begin
            addr_b.addr_high[31:0] = $urandom();
            addr_b.addr_low = {$urandom(), $urandom()};
        end while (home_index(1'b1, addr_b.addr_high, addr_b.addr_low) != 16);
        send_request(request_of(addr_a, MODE_LOOKUP, 32'd0, 32'd0));
        send_request(request_of(addr_a, MODE_STORE, 32'd100, 32'hFFFF_FFFF));
        send_request(request_of(addr_a_noise, MODE_LOOKUP, 32'd86499, 32'd0));
        send_request(request_of(addr_b, MODE_LOOKUP, 32'd86499, 32'd0));
        send_request(request_of(addr_a, MODE_LOOKUP, 32'd86500, 32'd0));
        send_request(request_of(addr_a, MODE_LOOKUP, 32'd100, 32'd0));
    endtask

    // Zero lifetime expires an entry at once; the largest lifetime makes the
    // expiry saturate at the top of the 32-bit range.
    task automatic test_ttl_limits();
        t_req addr_c;
        t_req addr_d;
        addr_c = address_for_home(32, 1'b1);
        addr_d = address_for_home(48, 1'b0);
        write_ttl(32'd0);
        send_request(request_of(addr_c, MODE_STORE, 32'hFFFF_FFFF, 32'd0));
        send_request(request_of(addr_c, MODE_LOOKUP, 32'd0, 32'd0));
        send_request(request_of(addr_c, MODE_STORE, 32'd5, 32'h1234_5678));
        send_request(request_of(addr_c, MODE_LOOKUP, 32'd5, 32'd0));
        write_ttl(32'hFFFF_FFFF);
        send_request(request_of(addr_d, MODE_STORE, 32'd10, $urandom()));
        send_request(request_of(addr_d, MODE_LOOKUP, 32'hFFFF_FFFE, 32'd0));
        send_request(request_of(addr_d, MODE_LOOKUP, 32'hFFFF_FFFF, 32'd0));
    endtask

    // Fills one probe window that wraps past the end of the table, forces an
    // eviction with two entries tied on the earliest expiry, then frees an
    // entry inside the chain so that a later entry can no longer be found.
    task automatic test_eviction_and_holes();
        t_req        chain [PROBE_WINDOW + 1];
        logic [31:0] stored_at;
        int          i;
        for (i = 0; i <= PROBE_WINDOW; i++) begin
            chain[i] = address_for_home(TABLE_ENTRIES - 4, 1'b0);
        end
        write_ttl(32'd100);
        for (i = 0; i < PROBE_WINDOW; i++) begin
            stored_at = (i == 3 || i == 5) ? 32'd990 : 32'd1000 + i;
            send_request(request_of(chain[i], MODE_STORE, stored_at, $urandom()));
        end
        // The window is full and live, so the first of the two oldest goes.
        send_request(request_of(chain[PROBE_WINDOW], MODE_STORE, 32'd1010, $urandom()));
        send_request(request_of(chain[PROBE_WINDOW], MODE_LOOKUP, 32'd1020, 32'd0));
        send_request(request_of(chain[3], MODE_LOOKUP, 32'd1020, 32'd0));
        send_request(request_of(chain[1], MODE_LOOKUP, 32'd1101, 32'd0));
        send_request(request_of(chain[2], MODE_LOOKUP, 32'd1050, 32'd0));
    endtask

    // Random traffic over a pool of addresses packed onto a few neighboring
    // home slots, so that windows overlap, fill up and evict. Each phase runs
    // with its own lifetime; the write between phases drains the cache.
    task automatic test_random_traffic();
        t_req        pool [POOL_SIZE];
        t_req        req;
        int          cluster [CLUSTER_HOMES];
        logic [31:0] phase_ttl [RANDOM_PHASES];
        logic [31:0] now_clock;
        int          phase;
        int          n;
        int          roll;
        int          pick;
        cluster = '{TABLE_ENTRIES - 3, TABLE_ENTRIES - 2, TABLE_ENTRIES - 1, 0, 1, 2};
        phase_ttl = '{32'd37, 32'd500, 32'd0, 32'hFFFF_FFFF, 32'd86400};
        for (n = 0; n < POOL_SIZE; n++) begin
            pool[n] = address_for_home(cluster[$urandom_range(0, CLUSTER_HOMES - 1)],
                                       $urandom_range(0, 2) == 0);
        end
        now_clock = $urandom();
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_ttl(phase_ttl[phase]);
            for (n = 0; n < PHASE_REQUESTS; n++) begin
                if (n % 40 == 0) begin
                    burst_mode = ($urandom_range(0, 3) == 0);
                end
                // Time mostly creeps forward; now and then it jumps, or
                // lands just below the top of its range.
                if ($urandom_range(0, 49) == 0) begin
                    now_clock = $urandom();
                end else if ($urandom_range(0, 199) == 0) begin
                    now_clock = 32'hFFFF_FFF0;
                end else begin
                    now_clock += $urandom_range(0, 12);
                end
                roll = $urandom_range(0, 99);
                pick = $urandom_range(0, POOL_SIZE - 1);
                if (roll < 75) begin
                    req = pool[pick];
                    req.mode = ($urandom_range(0, 99) < 45) ? MODE_STORE : MODE_LOOKUP;
                    if (!req.is_ipv6 && $urandom_range(0, 1) == 1) begin
                        req.addr_high[31:0] = $urandom();
                        req.addr_low = {$urandom(), $urandom()};
                    end
                end else if (roll < 90) begin
                    req.mode = $urandom_range(0, 1) ? MODE_STORE : MODE_LOOKUP;
                    req.is_ipv6 = 1'($urandom_range(0, 1));
                    req.addr_high = {$urandom(), $urandom()};
                    req.addr_low = {$urandom(), $urandom()};
                end else begin
                    // Near misses: a flipped address bit or the wrong family.
                    req = pool[pick];
                    req.mode = MODE_LOOKUP;
                    if (req.is_ipv6) begin
                        req.addr_low ^= 64'd1 << $urandom_range(0, 63);
                    end else begin
                        req.is_ipv6 = 1'b1;
                    end
                end
                req.now_seconds = now_clock;
                req.store_value = $urandom();
                send_request(req);
            end
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ttl_hash_cache_linear_probe verification failed");
        $finish;
    end

    initial begin
        start <= 1'b0;
        i_req <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        i_rst_n <= 1'b0;
        // Reset clears every valid mark and restores the default lifetime.
        foreach (shadow_live[i]) begin
            shadow_live[i] = 1'b0;
        end
        ttl_shadow = TTL_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_ttl_and_match();
        test_ttl_limits();
        test_eviction_and_holes();
        test_random_traffic();
        wait_until_idle();
        if (mismatch_count == 0 && pending_lookups.size() == 0) begin
            $display("ttl_hash_cache_linear_probe verification clean");
        end else begin
            $display("ttl_hash_cache_linear_probe verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/thc_pkg.sv
src/ttl_hash_cache_linear_probe.sv
bench/ttl_hash_cache_linear_probe_test.sv
